### rtl/assert_macros.svh
// Assertion macros shared by the calendar date adder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/cda_pkg.sv
// Package with types, constants and calendar functions of the date adder.
`timescale 1ns / 1ps

package cda_pkg;

    // Operation codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_SET        = 2'd0,
        MODE_ADD_DAYS   = 2'd1,
        MODE_ADD_MONTHS = 2'd2,
        MODE_ADD_YEARS  = 2'd3
    } mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_DAY   = 2'd2,
        ST_BAD_YEAR  = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step_fwd;
        logic step_bwd;
        logic clamp;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_fwd;
        logic need_bwd;
    } sts_t;

    localparam int YEAR_MAX    = 9999;
    localparam int MONTHS      = 12;
    localparam int RESET_DAY   = 1;
    localparam int RESET_MONTH = 1;
    localparam int RESET_YEAR  = 2000;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // floor(y / 25) = (y * 5243) >> 17, exact for all 14-bit y
    localparam int DIV25_RECIP = 5243;
    localparam int DIV25_SHIFT = 17;
    // floor(u / 3) = (u * 21846) >> 16, exact for all 15-bit u
    localparam int DIV3_RECIP  = 21846;
    // Bias that makes the month offset non-negative before the divide by 12
    localparam int MONTH_BIAS_Q = 2731;
    localparam int MONTH_BIAS   = MONTH_BIAS_Q * MONTHS;

    // Gregorian leap rule: y%400 == 0 iff y%16 == 0 and y%25 == 0
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [9:0]  quo;
        logic [13:0] rem;
        prod = 27'(y) * 27'(DIV25_RECIP);
        quo  = prod[26:DIV25_SHIFT];
        rem  = y - 14'({4'd0, quo} * 14'd25);
        return (y[1:0] == 2'd0) && ((rem != 14'd0) || (y[3:0] == 4'd0));
    endfunction

    // Days in month m of year y; codes outside 1..12 read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = is_leap(y) ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/cda_ctrl.sv
// Controller state machine of the calendar date adder.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_ctrl
    import cda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    output logic       out_valid,
    input  logic       out_stall,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_CLAMP = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Take a word only when no item is in flight
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one item: load, day walk or clamp for adds, then finish
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (mode) inside
                        MODE_SET:                        state_next = S_DONE;
                        MODE_ADD_DAYS:                   state_next = S_WALK;
                        MODE_ADD_MONTHS, MODE_ADD_YEARS: state_next = S_CLAMP;
                    endcase
                end
            end
            S_WALK:
            begin
                if (sts.need_bwd)
                begin
                    cmd.step_bwd = 1'b1;
                end
                else if (sts.need_fwd)
                begin
                    cmd.step_fwd = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word not held off")
    `ASSERT_ALWAYS(a_finish_free, !cmd.finish || !out_valid_reg || !out_stall, "result overwritten")
    `ASSERT_NEXT(a_result_after_finish, cmd.finish, out_valid, "finished item gave no result")

endmodule

### rtl/cda_dpath.sv
// Datapath of the calendar date adder: current date, work registers, result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_dpath
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  mode,
    input  logic [15:0] amount,
    input  logic [4:0]  new_day,
    input  logic [3:0]  new_month,
    input  logic [13:0] new_year,
    output logic [4:0]  out_day,
    output logic [3:0]  out_month,
    output logic [13:0] out_year,
    output logic [1:0]  status
);

    // Committed date
    logic [4:0]         cur_day_reg;
    logic [3:0]         cur_month_reg;
    logic [13:0]        cur_year_reg;

    // Work registers
    logic signed [16:0] d_reg, d_next;
    logic [3:0]         m_reg, m_next;
    logic signed [16:0] y_reg, y_next;
    status_t            status_reg, status_next;

    // Result registers
    logic [4:0]         out_day_reg;
    logic [3:0]         out_month_reg;
    logic [13:0]        out_year_reg;
    status_t            out_status_reg;

    logic signed [16:0] amount_ext;
    logic signed [16:0] cur_day_s;
    logic signed [16:0] cur_year_s;

    // Month add: floor division of the month offset by twelve
    logic signed [16:0] mon_off;
    logic [16:0]        mon_biased;
    logic [28:0]        mon_prod;
    logic [12:0]        mon_quo;
    logic [16:0]        mon_rem;

    // Month walk
    logic [4:0]         len_cur;
    logic [3:0]         m_dec;
    logic signed [16:0] y_dec;
    logic [4:0]         len_dec;
    logic [4:0]         len_new;
    logic               set_ok_month;
    logic [4:0]         len_set;
    status_t            final_status;

    assign amount_ext = $signed({amount[15], amount});
    assign cur_day_s  = $signed({12'd0, cur_day_reg});
    assign cur_year_s = $signed({3'd0, cur_year_reg});

    assign mon_off    = $signed({13'd0, cur_month_reg}) - 17'sd1 + amount_ext;
    assign mon_biased = 17'(mon_off) + 17'(MONTH_BIAS);
    assign mon_prod   = 29'(mon_biased[16:2]) * 29'(DIV3_RECIP);
    assign mon_quo    = mon_prod[28:16];
    assign mon_rem    = mon_biased - 17'({4'd0, mon_quo} * 17'd12);

    assign len_cur = month_len(m_reg, y_reg[13:0]);
    assign m_dec   = (m_reg == MONTH_JAN) ? MONTH_DEC : (m_reg - 4'd1);
    assign y_dec   = (m_reg == MONTH_JAN) ? (y_reg - 17'sd1) : y_reg;
    assign len_dec = month_len(m_dec, y_dec[13:0]);
    assign len_new = len_cur;

    assign set_ok_month = (new_month >= MONTH_JAN) && (new_month <= MONTH_DEC);
    assign len_set      = month_len(new_month, new_year);

    // Report which way the day walk still has to go
    assign sts.need_fwd = (d_reg > $signed({12'd0, len_cur}));
    assign sts.need_bwd = (d_reg < 17'sd1);

    // Reject any year outside the calendar range
    always_comb
    begin
        if ((status_reg == ST_OK) && ((y_reg < 17'sd0) || (y_reg > 17'(YEAR_MAX))))
        begin
            final_status = ST_BAD_YEAR;
        end
        else
        begin
            final_status = status_reg;
        end
    end

    // Work register update
    always_comb
    begin
        d_next      = d_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        status_next = status_reg;
        if (cmd.load)
        begin
            d_next      = cur_day_s;
            m_next      = cur_month_reg;
            y_next      = cur_year_s;
            status_next = ST_OK;
            unique case (mode)
                MODE_SET:
                begin
                    if (!set_ok_month)
                    begin
                        status_next = ST_BAD_MONTH;
                    end
                    else if ((new_day == 5'd0) || (new_day > len_set))
                    begin
                        status_next = ST_BAD_DAY;
                    end
                    else if (new_year > 14'(YEAR_MAX))
                    begin
                        status_next = ST_BAD_YEAR;
                    end
                    else
                    begin
                        d_next = $signed({12'd0, new_day});
                        m_next = new_month;
                        y_next = $signed({3'd0, new_year});
                    end
                end
                MODE_ADD_DAYS:
                begin
                    d_next = cur_day_s + amount_ext;
                end
                MODE_ADD_MONTHS:
                begin
                    m_next = mon_rem[3:0] + 4'd1;
                    y_next = cur_year_s + $signed({4'd0, mon_quo}) - 17'(MONTH_BIAS_Q);
                end
                MODE_ADD_YEARS:
                begin
                    y_next = cur_year_s + amount_ext;
                end
            endcase
        end
        else if (cmd.step_fwd)
        begin
            // Advance one month, dropping its length from the day count
            d_next = d_reg - $signed({12'd0, len_cur});
            if (m_reg == MONTH_DEC)
            begin
                m_next = MONTH_JAN;
                y_next = y_reg + 17'sd1;
            end
            else
            begin
                m_next = m_reg + 4'd1;
            end
        end
        else if (cmd.step_bwd)
        begin
            // Step back one month, adding the length of that month
            m_next = m_dec;
            y_next = y_dec;
            d_next = d_reg + $signed({12'd0, len_dec});
        end
        else if (cmd.clamp)
        begin
            // Clamp the day to the length of the new month
            if (d_reg > $signed({12'd0, len_new}))
            begin
                d_next = $signed({12'd0, len_new});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        m_reg      <= m_next;
        y_reg      <= y_next;
        status_reg <= status_next;
    end

    // Commit an accepted step to the current date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_day_reg   <= 5'(RESET_DAY);
            cur_month_reg <= 4'(RESET_MONTH);
            cur_year_reg  <= 14'(RESET_YEAR);
        end
        else if (cmd.finish && (final_status == ST_OK))
        begin
            cur_day_reg   <= d_reg[4:0];
            cur_month_reg <= m_reg;
            cur_year_reg  <= y_reg[13:0];
        end
    end

    // Load the result word: stepped date, or current date on an error
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (final_status == ST_OK)
            begin
                out_day_reg   <= d_reg[4:0];
                out_month_reg <= m_reg;
                out_year_reg  <= y_reg[13:0];
            end
            else
            begin
                out_day_reg   <= cur_day_reg;
                out_month_reg <= cur_month_reg;
                out_year_reg  <= cur_year_reg;
            end
            out_status_reg <= final_status;
        end
    end

    assign out_day   = out_day_reg;
    assign out_month = out_month_reg;
    assign out_year  = out_year_reg;
    assign status    = out_status_reg;

    `ASSERT_ALWAYS(a_cur_date_valid, (cur_month_reg >= MONTH_JAN) && (cur_month_reg <= MONTH_DEC) && (cur_day_reg != 5'd0) && (cur_year_reg <= 14'(YEAR_MAX)), "current date out of range")
    `ASSERT_ALWAYS(a_walk_month, !(cmd.step_fwd || cmd.step_bwd) || ((m_reg >= MONTH_JAN) && (m_reg <= MONTH_DEC)), "month out of range during walk")
    `ASSERT_ALWAYS(a_commit_day, !(cmd.finish && (final_status == ST_OK)) || ((d_reg >= 17'sd1) && (d_reg <= $signed({12'd0, len_cur}))), "committed day beyond month length")

endmodule

### rtl/calendar_date_adder.sv
// Top level of the calendar date adder: controller and datapath.
// Sequence: a set-date word goes from load to finish, add months or years passes through
// a clamp step, and add days walks one month boundary per step before the finish.
// Flow: one item at a time; no new word is taken until the current item has finished,
// and an item waits to finish while an untaken result stalls in the output register.
// Reset: asynchronous, active low; date becomes 1 January 2000, no result pending.
`timescale 1ns / 1ps

module calendar_date_adder
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] amount,
    input  logic [4:0]  new_day,
    input  logic [3:0]  new_month,
    input  logic [13:0] new_year,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  out_day,
    output logic [3:0]  out_month,
    output logic [13:0] out_year,
    output logic [1:0]  status
);

    cmd_t cmd;
    sts_t sts;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cda_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .amount    (amount),
        .new_day   (new_day),
        .new_month (new_month),
        .new_year  (new_year),
        .out_day   (out_day),
        .out_month (out_month),
        .out_year  (out_year),
        .status    (status)
    );

endmodule

### dv/calendar_date_adder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the calendar date adder: directed table, then random date words.
module calendar_date_adder_tb;
    import cda_pkg::*;

    localparam int RANDOM_WORDS   = 900;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 1200;
    localparam int WATCHDOG_LIMIT = 6000;

    // One request word as driven on the input ports
    typedef struct {
        mode_t       mode;
        logic [15:0] amount;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_req_t;

    // One result word as seen on the output ports
    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        status_t     st;
    } date_rsp_t;

    typedef struct {
        date_req_t req;
        bit        known;
        date_rsp_t want;
    } table_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    mode_t       mode      = MODE_SET;
    logic [15:0] amount    = '0;
    logic [4:0]  new_day   = '0;
    logic [3:0]  new_month = '0;
    logic [13:0] new_year  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [1:0]  status;

    // Date tracked by the predictor
    logic [4:0]  cal_day   = 5'(RESET_DAY);
    logic [3:0]  cal_month = 4'(RESET_MONTH);
    logic [13:0] cal_year  = 14'(RESET_YEAR);

    date_rsp_t  pending_dates[$];
    table_row_t directed_rows[$];

    int mismatch_count = 0;
    int holdoff_left   = 0;
    int quiet_cycles   = 0;
    bit calm           = 1'b0;
    bit holdoff_req    = 1'b0;

    calendar_date_adder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .amount    (amount),
        .new_day   (new_day),
        .new_month (new_month),
        .new_year  (new_year),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_day   (out_day),
        .out_month (out_month),
        .out_year  (out_year),
        .status    (status)
    );

    always #6 clk = ~clk;

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in(int m, int y);
        int len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = leap_year(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Apply one request to the tracked date and return the word the block should give
    function automatic date_rsp_t advance_date(date_req_t r);
        int        d;
        int        m;
        int        y;
        int        amt;
        int        t;
        int        q;
        int        rem;
        date_rsp_t rsp;
        d      = cal_day;
        m      = cal_month;
        y      = cal_year;
        amt    = $signed(r.amount);
        rsp.st = ST_OK;
        case (r.mode)
            MODE_SET:
            begin
                if (r.month < 1 || r.month > MONTHS)
                    rsp.st = ST_BAD_MONTH;
                else if (r.day < 1 || r.day > days_in(r.month, r.year))
                    rsp.st = ST_BAD_DAY;
                else if (r.year > YEAR_MAX)
                    rsp.st = ST_BAD_YEAR;
                else
                begin
                    d = r.day;
                    m = r.month;
                    y = r.year;
                end
            end
            MODE_ADD_DAYS:
            begin
                // walk forward or backward one month at a time
                d += amt;
                while (d > days_in(m, y))
                begin
                    d -= days_in(m, y);
                    m++;
                    if (m > MONTHS)
                    begin
                        m = 1;
                        y++;
                    end
                end
                while (d < 1)
                begin
                    m--;
                    if (m < 1)
                    begin
                        m = MONTHS;
                        y--;
                    end
                    d += days_in(m, y);
                end
            end
            MODE_ADD_MONTHS:
            begin
                // floor division carries whole years, then clamp the day
                t   = (m - 1) + amt;
                q   = t / MONTHS;
                rem = t % MONTHS;
                if (rem < 0)
                begin
                    rem += MONTHS;
                    q   -= 1;
                end
                m = rem + 1;
                y += q;
                if (d > days_in(m, y))
                    d = days_in(m, y);
            end
            default:
            begin
                // leap day falls back to the 28th in a common year
                y += amt;
                if (m == 2 && d == 29 && !leap_year(y))
                    d = 28;
            end
        endcase
        if (rsp.st == ST_OK && (y < 0 || y > YEAR_MAX))
            rsp.st = ST_BAD_YEAR;
        if (rsp.st == ST_OK)
        begin
            cal_day   = 5'(d);
            cal_month = 4'(m);
            cal_year  = 14'(y);
        end
        rsp.day   = cal_day;
        rsp.month = cal_month;
        rsp.year  = cal_year;
        return rsp;
    endfunction

    // Draw a random request: mostly well-formed dates and modest counts, some noise
    function automatic date_req_t random_req();
        date_req_t r;
        int        pick;
        int        sel;
        r.mode   = MODE_SET;
        r.amount = 16'($urandom);
        r.day    = 5'($urandom);
        r.month  = 4'($urandom);
        r.year   = 14'($urandom);
        pick     = $urandom_range(99);
        if (pick < 25)
        begin
            if ($urandom_range(99) < 70)
            begin
                r.year  = 14'($urandom_range(YEAR_MAX));
                r.month = 4'($urandom_range(MONTHS, 1));
                case ($urandom_range(7))
                    0:
                    begin
                        // end of February in a year divisible by four
                        r.month = MONTH_FEB;
                        r.year  = 14'(4 * $urandom_range(2499));
                        r.day   = 5'(days_in(r.month, r.year));
                    end
                    1: r.day = 5'(days_in(r.month, r.year));
                    2:
                    begin
                        r.year = $urandom_range(1) ? 14'd0 : 14'(YEAR_MAX);
                        r.day  = 5'($urandom_range(days_in(r.month, r.year), 1));
                    end
                    default: r.day = 5'($urandom_range(days_in(r.month, r.year), 1));
                endcase
            end
        end
        else
        begin
            if (pick < 60)
                r.mode = MODE_ADD_DAYS;
            else if (pick < 80)
                r.mode = MODE_ADD_MONTHS;
            else
                r.mode = MODE_ADD_YEARS;
            sel = $urandom_range(99);
            if (sel < 55)
                r.amount = 16'($urandom_range(120) - 60);
            else if (sel < 80)
                r.amount = 16'($urandom_range(4000) - 2000);
            else if (sel < 92)
                r.amount = 16'($urandom);
            else
            begin
                case ($urandom_range(4))
                    0:       r.amount = 16'h8000;
                    1:       r.amount = 16'h7fff;
                    2:       r.amount = 16'hffff;
                    3:       r.amount = 16'h0001;
                    default: r.amount = 16'h0000;
                endcase
            end
        end
        return r;
    endfunction

    task automatic put_row(mode_t m, int amt, int d, int mo, int y, bit known = 1'b0,
                           int wd = 0, int wm = 0, int wy = 0, status_t ws = ST_OK);
        table_row_t row;
        row.req.mode   = m;
        row.req.amount = 16'(amt);
        row.req.day    = 5'(d);
        row.req.month  = 4'(mo);
        row.req.year   = 14'(y);
        row.known      = known;
        row.want.day   = 5'(wd);
        row.want.month = 4'(wm);
        row.want.year  = 14'(wy);
        row.want.st    = ws;
        directed_rows.push_back(row);
    endtask

    // Offer one word, hold it until taken, then queue its expected result
    task automatic send_word(date_req_t r, bit known, date_rsp_t want);
        date_rsp_t predicted;
        while (!calm && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= r.mode;
        amount    <= r.amount;
        new_day   <= r.day;
        new_month <= r.month;
        new_year  <= r.year;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_date(r);
        if (known)
            pending_dates.push_back(want);
        else
            pending_dates.push_back(predicted);
    endtask

    // Drive reset, the directed table, then the random words
    initial
    begin : stimulus
        date_rsp_t none;
        none.day   = '0;
        none.month = '0;
        none.year  = '0;
        none.st    = ST_OK;
        put_row(MODE_ADD_DAYS,   0,      0,  0,  0,     1, 1,  1,  2000, ST_OK);
        put_row(MODE_SET,        0,      1,  0,  2000,  1, 1,  1,  2000, ST_BAD_MONTH);
        put_row(MODE_SET,        -32768, 31, 15, 16383, 1, 1,  1,  2000, ST_BAD_MONTH);
        put_row(MODE_SET,        0,      0,  1,  2000,  1, 1,  1,  2000, ST_BAD_DAY);
        put_row(MODE_SET,        0,      30, 2,  2000,  1, 1,  1,  2000, ST_BAD_DAY);
        put_row(MODE_SET,        0,      29, 2,  1900,  1, 1,  1,  2000, ST_BAD_DAY);
        put_row(MODE_SET,        0,      31, 4,  2001,  1, 1,  1,  2000, ST_BAD_DAY);
        put_row(MODE_SET,        0,      1,  1,  10000, 1, 1,  1,  2000, ST_BAD_YEAR);
        put_row(MODE_SET,        0,      31, 12, 16383, 1, 1,  1,  2000, ST_BAD_YEAR);
        put_row(MODE_SET,        0,      29, 2,  2000,  1, 29, 2,  2000, ST_OK);
        put_row(MODE_ADD_YEARS,  1,      0,  0,  0);
        put_row(MODE_ADD_YEARS,  -1,     0,  0,  0);
        put_row(MODE_SET,        0,      31, 1,  2001,  1, 31, 1,  2001, ST_OK);
        put_row(MODE_ADD_MONTHS, 1,      0,  0,  0);
        put_row(MODE_ADD_MONTHS, -14,    0,  0,  0);
        put_row(MODE_ADD_DAYS,   400,    0,  0,  0);
        put_row(MODE_ADD_DAYS,   -800,   0,  0,  0);
        put_row(MODE_SET,        0,      1,  1,  0,     1, 1,  1,  0,    ST_OK);
        put_row(MODE_ADD_DAYS,   -1,     0,  0,  0,     1, 1,  1,  0,    ST_BAD_YEAR);
        put_row(MODE_ADD_MONTHS, -1,     0,  0,  0,     1, 1,  1,  0,    ST_BAD_YEAR);
        put_row(MODE_SET,        0,      31, 12, 9999,  1, 31, 12, 9999, ST_OK);
        put_row(MODE_ADD_DAYS,   1,      0,  0,  0,     1, 31, 12, 9999, ST_BAD_YEAR);
        put_row(MODE_ADD_DAYS,   -32768, 0,  0,  0);
        put_row(MODE_ADD_MONTHS, 32767,  0,  0,  0);
        put_row(MODE_ADD_YEARS,  -32768, 0,  0,  0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // hold off the output while input keeps coming
            if (n == 300)
                holdoff_req = 1'b1;
            // let everything drain before going on
            if (n == 600)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_dates.size() != 0)
                    @(posedge clk);
            end
            calm = (n >= 400 && n < 550);
            send_word(random_req(), 1'b0, none);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_dates.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_dates.size());
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Check each taken result word, then choose the stall for the next cycle
    initial
    begin : result_sink
        date_rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_dates.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %0d-%0d-%0d status %0d",
                             $time, out_year, out_month, out_day, status);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    if (out_day !== want.day)
                    begin
                        $display("%0t: out_day expected %0d, got %0d", $time, want.day, out_day);
                        mismatch_count++;
                    end
                    if (out_month !== want.month)
                    begin
                        $display("%0t: out_month expected %0d, got %0d",
                                 $time, want.month, out_month);
                        mismatch_count++;
                    end
                    if (out_year !== want.year)
                    begin
                        $display("%0t: out_year expected %0d, got %0d", $time, want.year, out_year);
                        mismatch_count++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.st, status);
                        mismatch_count++;
                    end
                end
            end
            if (holdoff_req)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_req  = 1'b0;
            end
            if (holdoff_left > 0)
            begin
                out_stall <= 1'b1;
                holdoff_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 14);
        end
    end

    // Count cycles with no word taken on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
